// ----- hdl/gshare_branch_predictor_macros.svh -----
// Assertion macros shared by the gshare predictor RTL.
// Needs clk and rst_n in the scope of use.
`ifndef GSHARE_BRANCH_PREDICTOR_MACROS_SVH
`define GSHARE_BRANCH_PREDICTOR_MACROS_SVH

// Same-cycle implication.
`define GBP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/gbp_pkg.sv -----
// Package for the gshare branch predictor: sizes, beat types, register indexes.
// No dependencies.
`timescale 1ns / 1ps

package gbp_pkg;

    localparam int MAX_INDEX_BITS = 12;
    localparam int TABLE_DEPTH    = 1 << MAX_INDEX_BITS;
    localparam int HIST_W         = 32;
    localparam int TOTAL_W        = 32;
    localparam int ADDR_W         = 32;
    localparam int IB_W           = 4;
    localparam int HB_W           = 6;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 6;
    localparam int CTR_W          = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_BITS = 2'd1;

    localparam logic [IB_W-1:0] IB_RESET = 4'd12;
    localparam logic [HB_W-1:0] HB_RESET = 6'd12;

    typedef logic [MAX_INDEX_BITS-1:0] idx_t;
    typedef logic [CTR_W-1:0]          ctr_t;
    typedef logic [TOTAL_W-1:0]        total_t;

    typedef struct packed {
        logic [ADDR_W-1:0] branch_address;
        logic              taken;
    } in_beat_t;

    typedef struct packed {
        logic   predicted_taken;
        logic   correct;
        idx_t   table_index;
        total_t correct_taken_count;
        total_t correct_not_taken_count;
        total_t wrong_taken_count;
        total_t wrong_not_taken_count;
    } out_beat_t;

endpackage

// ----- hdl/gshare_branch_predictor.sv -----
// Gshare branch predictor top level: history, index, counter update, totals.
// Depends on gbp_pkg, gbp_ram and gshare_branch_predictor_macros.svh.
`timescale 1ns / 1ps
`include "gshare_branch_predictor_macros.svh"

// Usage
//   in_valid/in_ready/in_data carry one branch beat: address and actual outcome.
//   out_valid/out_ready/out_data return one result beat per branch, in order:
//   prediction, hit flag, table index and the four saturating outcome totals.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write index_bits (0) or
//   history_bits (1); other indexes are dropped. Write only while idle.
// Timing
//   One branch per cycle sustained while out_ready stays high. Each input beat
//   goes through the counter table read into the update stage, then the update
//   and output register. The counter table is a one-read, one-write RAM; an entry
//   written in the same cycle as a new read is forwarded from a write register.
// Reset
//   After rst_n releases, the table is cleared one entry per cycle, all 4096
//   entries, with in_ready low; config writes are taken during that time.
// Backpressure
//   With out_ready low one more branch is taken into the update stage, then
//   in_ready drops until the output register drains.
module gshare_branch_predictor (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  gbp_pkg::in_beat_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output gbp_pkg::out_beat_t                out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gbp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gbp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import gbp_pkg::*;

    logic [IB_W-1:0]   index_bits_reg;
    logic [HB_W-1:0]   history_bits_reg;
    logic [HIST_W-1:0] hist_reg, hist_next;
    logic              clear_reg;
    idx_t              clr_addr_reg;

    logic              s1_valid_reg;
    idx_t              s1_idx_reg;
    logic              s1_taken_reg;

    logic              wr_valid_reg;
    idx_t              wr_idx_reg;
    ctr_t              wr_ctr_reg;

    total_t            hit_t_reg, hit_n_reg, miss_t_reg, miss_n_reg;
    total_t            hit_t_next, hit_n_next, miss_t_next, miss_n_next;

    logic              out_valid_reg;
    out_beat_t         out_data_reg;

    logic [IB_W-1:0]   ib_eff;
    logic [HB_W-1:0]   hb_eff;
    idx_t              idx_mask;
    logic [HIST_W-1:0] hist_mask;
    logic              in_fire;
    idx_t              in_idx;
    logic              s1_adv;
    ctr_t              ctr_cur, ctr_new;
    logic              pred, hit;
    logic [3:0]        inc_sel;
    logic              ram_we;
    idx_t              ram_waddr;
    ctr_t              ram_wdata, ram_rdata;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        ib_eff    = (index_bits_reg > IB_W'(MAX_INDEX_BITS)) ? IB_W'(MAX_INDEX_BITS)
                                                             : index_bits_reg;
        hb_eff    = (history_bits_reg > HB_W'(HIST_W)) ? HB_W'(HIST_W) : history_bits_reg;
        idx_mask  = ~({MAX_INDEX_BITS{1'b1}} << ib_eff);
        hist_mask = ~({HIST_W{1'b1}} << hb_eff);

        s1_adv    = s1_valid_reg && (!out_valid_reg || out_ready);
        in_ready  = !clear_reg && (!s1_valid_reg || s1_adv);
        in_fire   = in_valid && in_ready;
        in_idx    = (hist_reg[MAX_INDEX_BITS-1:0]
                     ^ in_data.branch_address[MAX_INDEX_BITS-1:0]) & idx_mask;
        hist_next = {hist_reg[HIST_W-2:0], in_data.taken} & hist_mask;

        ctr_cur = (wr_valid_reg && (wr_idx_reg == s1_idx_reg)) ? wr_ctr_reg : ram_rdata;
        pred    = ctr_cur[1];
        hit     = (pred == s1_taken_reg);
        if (s1_taken_reg)
        begin
            ctr_new = (ctr_cur == 2'd3) ? ctr_cur : ctr_cur + 2'd1;
        end
        else
        begin
            ctr_new = (ctr_cur == 2'd0) ? ctr_cur : ctr_cur - 2'd1;
        end

        // at most one set: hit taken, hit not taken, miss taken, miss not taken
        inc_sel[0] = s1_adv && hit && s1_taken_reg;
        inc_sel[1] = s1_adv && hit && !s1_taken_reg;
        inc_sel[2] = s1_adv && !hit && s1_taken_reg;
        inc_sel[3] = s1_adv && !hit && !s1_taken_reg;
        hit_t_next  = (inc_sel[0] && !(&hit_t_reg))  ? hit_t_reg + 1'b1  : hit_t_reg;
        hit_n_next  = (inc_sel[1] && !(&hit_n_reg))  ? hit_n_reg + 1'b1  : hit_n_reg;
        miss_t_next = (inc_sel[2] && !(&miss_t_reg)) ? miss_t_reg + 1'b1 : miss_t_reg;
        miss_n_next = (inc_sel[3] && !(&miss_n_reg)) ? miss_n_reg + 1'b1 : miss_n_reg;

        if (clear_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = s1_adv;
            ram_waddr = s1_idx_reg;
            ram_wdata = ctr_new;
        end
    end

    gbp_ram #(
        .WIDTH (CTR_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_fire),
        .raddr (in_idx),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_bits_reg   <= IB_RESET;
            history_bits_reg <= HB_RESET;
            hist_reg         <= '0;
            clear_reg        <= 1'b1;
            clr_addr_reg     <= '0;
            s1_valid_reg     <= 1'b0;
            wr_valid_reg     <= 1'b0;
            hit_t_reg        <= '0;
            hit_n_reg        <= '0;
            miss_t_reg       <= '0;
            miss_n_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_INDEX_BITS:   index_bits_reg   <= cfg_data[IB_W-1:0];
                    CFG_HISTORY_BITS: history_bits_reg <= cfg_data[HB_W-1:0];
                    default:          ;
                endcase
            end

            if (clear_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (&clr_addr_reg)
                begin
                    clear_reg <= 1'b0;
                end
            end

            if (in_fire)
            begin
                hist_reg <= hist_next;
            end

            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                wr_valid_reg <= 1'b1;
            end

            hit_t_reg  <= hit_t_next;
            hit_n_reg  <= hit_n_next;
            miss_t_reg <= miss_t_next;
            miss_n_reg <= miss_n_next;

            out_valid_reg <= s1_adv || (out_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_idx_reg   <= in_idx;
            s1_taken_reg <= in_data.taken;
        end
        if (s1_adv)
        begin
            wr_idx_reg                           <= s1_idx_reg;
            wr_ctr_reg                           <= ctr_new;
            out_data_reg.predicted_taken         <= pred;
            out_data_reg.correct                 <= hit;
            out_data_reg.table_index             <= s1_idx_reg;
            out_data_reg.correct_taken_count     <= hit_t_next;
            out_data_reg.correct_not_taken_count <= hit_n_next;
            out_data_reg.wrong_taken_count       <= miss_t_next;
            out_data_reg.wrong_not_taken_count   <= miss_n_next;
        end
    end

    `GBP_ASSERT_NOW(a_no_accept_in_clear, clear_reg, !in_ready, "branch accepted during table clear")
    `GBP_ASSERT_NOW(a_one_total_bump, 1'b1, $onehot0(inc_sel), "more than one total bumped")
    `GBP_ASSERT_NEXT(a_fwd_tracks_write, s1_adv, wr_valid_reg && (wr_idx_reg == $past(s1_idx_reg)), "forward register missed a table write")
    `GBP_ASSERT_NEXT(a_s1_holds, s1_valid_reg && !s1_adv, s1_valid_reg && $stable(s1_idx_reg), "stalled update stage lost its entry")

endmodule

// ----- hdl/gbp_ram.sv -----
// Generic single-write, single-read RAM with registered, read-first output.
// No dependencies.
`timescale 1ns / 1ps

module gbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
